// ===== hdl/alux_pkg.sv =====
// Shared types, constants and table functions for the two-channel lux block.
`default_nettype none

package alux_pkg;

	localparam int CNT_W = 16;          // ADC count width
	localparam int LUX_W = 27;          // lux result width, Q16
	localparam int POW_FRAC = 20;       // power table is unsigned Q20
	localparam int POW_W = 20;          // power table entry width
	localparam int MIX_W = 28;          // linear mix width (A*b - C*ir)
	localparam int BIG_W = 200;         // exact compare width for table build

	// ratio thresholds, in hundredths, compared against 100*ir
	localparam int RATIO_SCALE = 100;
	localparam int THR_LOW = 50;
	localparam int THR_MID = 61;
	localparam int THR_UPPER = 80;
	localparam int THR_IR = 130;

	// low band: broad * (304*2^20 - 620*p) / 160000
	localparam logic [28:0] LOW_BASE = 29'd318767104;
	localparam int LOW_SLOPE = 620;
	localparam int LOW_PRE_SHIFT = 8;              // 160000 = 625 * 2^8
	localparam int LOW_DIV = 625;
	localparam logic [27:0] LOW_RECIP = 28'd219902325; // floor(2^37 / 625)
	localparam int LOW_RECIP_SHIFT = 37;

	// linear bands: diff * 2^16 / 100000 = diff * 2^11 / 3125
	localparam int MIX_UP_SHIFT = 11;
	localparam int MIX_DIV = 3125;
	localparam logic [27:0] MIX_RECIP = 28'd175921860; // floor(2^39 / 3125)
	localparam int MIX_RECIP_SHIFT = 28;

	typedef enum logic [2:0] {
		BAND_ZERO  = 3'd0,  // broad count zero
		BAND_LOW   = 3'd1,  // ratio <= 0.50
		BAND_MID   = 3'd2,  // ratio <= 0.61
		BAND_UPPER = 3'd3,  // ratio <= 0.80
		BAND_IR    = 3'd4,  // ratio <= 1.30
		BAND_HIGH  = 3'd5   // ratio above 1.30
	} band_t;

	function automatic logic [11:0] mix_gain_broad(band_t bd);
		logic [11:0] g;
		case (bd)
			BAND_MID:   g = 12'd2240;
			BAND_UPPER: g = 12'd1280;
			BAND_IR:    g = 12'd146;
			default:    g = 12'd0;
		endcase
		return g;
	endfunction

	function automatic logic [11:0] mix_gain_ir(band_t bd);
		logic [11:0] g;
		case (bd)
			BAND_MID:   g = 12'd3100;
			BAND_UPPER: g = 12'd1530;
			BAND_IR:    g = 12'd112;
			default:    g = 12'd0;
		endcase
		return g;
	endfunction

	// y / 2^20 <= (i / (2*depth))^(7/5), checked as y^5 * (2*depth)^7 <= i^7 * 2^100
	function automatic logic pow_fits(int y, int i, int depth);
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] rhs;
		lhs = BIG_W'(1);
		rhs = BIG_W'(1);
		for (int k = 0; k < 5; k++) lhs = lhs * BIG_W'(unsigned'(y));
		for (int k = 0; k < 7; k++) lhs = lhs * BIG_W'(unsigned'(2 * depth));
		for (int k = 0; k < 7; k++) rhs = rhs * BIG_W'(unsigned'(i));
		rhs = rhs << (5 * POW_FRAC);
		return lhs <= rhs;
	endfunction

	// floor(2^20 * (i / (2*depth))^1.4), by bisection; elaboration only
	function automatic logic [POW_W-1:0] pow_entry(int i, int depth);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = 1 << POW_FRAC;
		for (int k = 0; k <= POW_FRAC; k++) begin
			if (hi - lo > 1) begin
				mid = lo + ((hi - lo) >> 1);
				if (pow_fits(mid, i, depth)) begin
					lo = mid;
				end else begin
					hi = mid;
				end
			end
		end
		return POW_W'(unsigned'(lo));
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ambient_lux_from_two_channel_adc_top.sv =====
// Top level: pipelined lux approximation from broadband and infrared ADC counts.
//
// Usage
//   Input channel: broad_count and ir_count, one pair per beat on
//   pair_valid / pair_stall. Output channel: lux_q16 (unsigned Q16, floored,
//   clamped at zero) and band (ratio band code) on lux_valid / lux_stall.
//   Every input beat yields exactly one output beat, in order.
// Stages and throughput
//   One stage for band select, FRAC_BITS stages of a radix-2 restoring
//   divider for ir/broad, then index rounding, power table read, low-band
//   coefficient, product, reciprocal partial products, reciprocal sum, and
//   the remainder correction into the output register.
//   One beat per cycle sustained unless the output is stalled.
// Stall
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out behind a stalled result. pair_stall is raised
//   only when every stage holds an item and the output is stalled.
// Reset
//   arst_n clears all stage valid bits; data registers are not reset.
//   The power table is a constant built at elaboration: no fill pass.
`default_nettype none

module ambient_lux_from_two_channel_adc_top #(
	parameter int FRAC_BITS = 16,
	parameter int POW_TABLE_DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         pair_valid,
	output logic                              pair_stall,
	input  wire logic [alux_pkg::CNT_W-1:0]   broad_count,
	input  wire logic [alux_pkg::CNT_W-1:0]   ir_count,
	output logic                              lux_valid,
	input  wire logic                         lux_stall,
	output logic      [alux_pkg::LUX_W-1:0]   lux_q16,
	output logic      [2:0]                   band
);

	localparam int CW = alux_pkg::CNT_W;
	localparam int IDX_W = $clog2(POW_TABLE_DEPTH + 1);
	localparam int TWO_D = 2 * POW_TABLE_DEPTH;
	localparam int TD_W = $clog2(TWO_D + 1);
	localparam int RND_W = FRAC_BITS + TD_W + 1;   // r*2D plus half, with carry
	localparam int IRAW_W = RND_W - FRAC_BITS;
	localparam int PW = alux_pkg::POW_W;
	localparam int MW = alux_pkg::MIX_W;
	localparam int M_W = CW + 29;                  // broad * low coefficient
	localparam int X1_W = M_W - alux_pkg::LOW_PRE_SHIFT;
	localparam int X1_HI_W = X1_W - 16;
	localparam int P1_W = X1_W + 28;
	localparam int PL_W = MW + 28;
	localparam int R1_W = X1_W + 1;
	localparam int RL_W = MW + alux_pkg::MIX_UP_SHIFT;

	// ------------------------------------------------------------------
	// Power table, (i / 2D)^1.4 in Q20, built at elaboration.
	// ------------------------------------------------------------------
	logic [PW-1:0] pow_rom [POW_TABLE_DEPTH+1];

	for (genvar gi = 0; gi <= POW_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [PW-1:0] ENTRY = alux_pkg::pow_entry(gi, POW_TABLE_DEPTH);
		assign pow_rom[gi] = ENTRY;
	end

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when empty or when its successor loads.
	// ------------------------------------------------------------------
	logic                 v_s1, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic                 v_s2 [FRAC_BITS];
	logic                 en_s1, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic                 en_s2 [FRAC_BITS];

	assign en_s9 = !v_s9 || !lux_stall;
	assign en_s8 = !v_s8 || en_s9;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s1 = !v_s1 || en_s2[0];

	assign pair_stall = !en_s1;

	// ------------------------------------------------------------------
	// S1: band select by exact cross multiplication.
	// ------------------------------------------------------------------
	logic [23:0]     ir_x100, b_x50, b_x61, b_x80, b_x130;
	alux_pkg::band_t band_in;

	assign ir_x100 = 24'(ir_count) * 24'(alux_pkg::RATIO_SCALE);
	assign b_x50   = 24'(broad_count) * 24'(alux_pkg::THR_LOW);
	assign b_x61   = 24'(broad_count) * 24'(alux_pkg::THR_MID);
	assign b_x80   = 24'(broad_count) * 24'(alux_pkg::THR_UPPER);
	assign b_x130  = 24'(broad_count) * 24'(alux_pkg::THR_IR);

	always_comb begin
		if (broad_count == '0) begin
			band_in = alux_pkg::BAND_ZERO;
		end else if (ir_x100 <= b_x50) begin
			band_in = alux_pkg::BAND_LOW;
		end else if (ir_x100 <= b_x61) begin
			band_in = alux_pkg::BAND_MID;
		end else if (ir_x100 <= b_x80) begin
			band_in = alux_pkg::BAND_UPPER;
		end else if (ir_x100 <= b_x130) begin
			band_in = alux_pkg::BAND_IR;
		end else begin
			band_in = alux_pkg::BAND_HIGH;
		end
	end

	logic [CW-1:0]   b_s1, ir_s1;
	alux_pkg::band_t band_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			b_s1    <= broad_count;
			ir_s1   <= ir_count;
			band_s1 <= band_in;
		end
	end

	// ------------------------------------------------------------------
	// S2: restoring divider, one quotient bit per step, r = ir*2^F / broad.
	// Only the low band needs r; other items divide zero.
	// ------------------------------------------------------------------
	logic [CW-1:0]        rem_s2  [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_s2  [FRAC_BITS];
	logic [CW-1:0]        b_s2    [FRAC_BITS];
	logic [CW-1:0]        ir_s2   [FRAC_BITS];
	alux_pkg::band_t      band_s2 [FRAC_BITS];

	logic                 dv_v_in    [FRAC_BITS];
	logic [CW-1:0]        dv_rem_in  [FRAC_BITS];
	logic [FRAC_BITS-1:0] dv_quo_in  [FRAC_BITS];
	logic [CW-1:0]        dv_b_in    [FRAC_BITS];
	logic [CW-1:0]        dv_ir_in   [FRAC_BITS];
	alux_pkg::band_t      dv_band_in [FRAC_BITS];

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
		logic [CW:0] sh;
		logic        ge;

		if (k == 0) begin : g_head
			assign dv_v_in[k]    = v_s1;
			assign dv_rem_in[k]  = (band_s1 == alux_pkg::BAND_LOW) ? ir_s1 : '0;
			assign dv_quo_in[k]  = '0;
			assign dv_b_in[k]    = b_s1;
			assign dv_ir_in[k]   = ir_s1;
			assign dv_band_in[k] = band_s1;
		end else begin : g_body
			assign dv_v_in[k]    = v_s2[k-1];
			assign dv_rem_in[k]  = rem_s2[k-1];
			assign dv_quo_in[k]  = quo_s2[k-1];
			assign dv_b_in[k]    = b_s2[k-1];
			assign dv_ir_in[k]   = ir_s2[k-1];
			assign dv_band_in[k] = band_s2[k-1];
		end

		if (k == FRAC_BITS - 1) begin : g_tail
			assign en_s2[k] = !v_s2[k] || en_s3;
		end else begin : g_link
			assign en_s2[k] = !v_s2[k] || en_s2[k+1];
		end

		assign sh = {dv_rem_in[k], 1'b0};
		assign ge = sh >= {1'b0, dv_b_in[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (en_s2[k]) begin
				v_s2[k] <= dv_v_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s2[k]) begin
				rem_s2[k]  <= ge ? CW'(sh - {1'b0, dv_b_in[k]}) : CW'(sh);
				quo_s2[k]  <= {dv_quo_in[k][FRAC_BITS-2:0], ge};
				b_s2[k]    <= dv_b_in[k];
				ir_s2[k]   <= dv_ir_in[k];
				band_s2[k] <= dv_band_in[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// S3: table index (ratio rounded half up, capped) and linear mix.
	// ------------------------------------------------------------------
	logic [FRAC_BITS-1:0] ratio_d;
	logic [CW-1:0]        b_d, ir_d;
	alux_pkg::band_t      band_d;
	logic [RND_W-1:0]     rnd;
	logic [IRAW_W-1:0]    idx_raw;
	logic [IDX_W-1:0]     idx_in;
	logic [MW-1:0]        mix_pos, mix_neg, mix_in;

	assign ratio_d = quo_s2[FRAC_BITS-1];
	assign b_d     = b_s2[FRAC_BITS-1];
	assign ir_d    = ir_s2[FRAC_BITS-1];
	assign band_d  = band_s2[FRAC_BITS-1];

	assign rnd     = RND_W'(ratio_d) * RND_W'(TWO_D) + (RND_W'(1) << (FRAC_BITS - 1));
	assign idx_raw = IRAW_W'(rnd >> FRAC_BITS);
	assign idx_in  = (idx_raw > IRAW_W'(POW_TABLE_DEPTH)) ? IDX_W'(POW_TABLE_DEPTH)
	                                                    : IDX_W'(idx_raw);

	assign mix_pos = MW'(b_d) * MW'(alux_pkg::mix_gain_broad(band_d));
	assign mix_neg = MW'(ir_d) * MW'(alux_pkg::mix_gain_ir(band_d));
	assign mix_in  = (mix_pos > mix_neg) ? mix_pos - mix_neg : '0;

	logic [IDX_W-1:0] idx_s3;
	logic [CW-1:0]    b_s3;
	logic [MW-1:0]    mix_s3;
	alux_pkg::band_t  band_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2[FRAC_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			idx_s3  <= idx_in;
			b_s3    <= b_d;
			mix_s3  <= mix_in;
			band_s3 <= band_d;
		end
	end

	// ------------------------------------------------------------------
	// S4: registered table read.
	// ------------------------------------------------------------------
	logic [PW-1:0]   pow_s4;
	logic [CW-1:0]   b_s4;
	logic [MW-1:0]   mix_s4;
	alux_pkg::band_t band_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			pow_s4  <= pow_rom[idx_s3];
			b_s4    <= b_s3;
			mix_s4  <= mix_s3;
			band_s4 <= band_s3;
		end
	end

	// ------------------------------------------------------------------
	// S5: low-band coefficient 304*2^20 - 620*p, clamped at zero.
	// ------------------------------------------------------------------
	logic [29:0] slope_p;
	logic [28:0] coef_in;

	assign slope_p = 30'(pow_s4) * 30'(alux_pkg::LOW_SLOPE);
	assign coef_in = (slope_p >= 30'(alux_pkg::LOW_BASE)) ? '0
	               : 29'(30'(alux_pkg::LOW_BASE) - slope_p);

	logic [28:0]     coef_s5;
	logic [CW-1:0]   b_s5;
	logic [MW-1:0]   mix_s5;
	alux_pkg::band_t band_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			coef_s5 <= coef_in;
			b_s5    <= b_s4;
			mix_s5  <= mix_s4;
			band_s5 <= band_s4;
		end
	end

	// ------------------------------------------------------------------
	// S6: low-band product broad*coef; linear mix times reciprocal of 3125.
	// ------------------------------------------------------------------
	logic [M_W-1:0]  m_s6;
	logic [PL_W-1:0] prodl_s6;
	logic [MW-1:0]   mix_s6;
	alux_pkg::band_t band_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			m_s6     <= M_W'(b_s5) * M_W'(coef_s5);
			prodl_s6 <= PL_W'(mix_s5) * PL_W'(alux_pkg::MIX_RECIP);
			mix_s6   <= mix_s5;
			band_s6  <= band_s5;
		end
	end

	// ------------------------------------------------------------------
	// S7: (m >> 8) times reciprocal of 625, split in two partial products.
	// ------------------------------------------------------------------
	logic [X1_W-1:0] x1_d;

	assign x1_d = m_s6[M_W-1:alux_pkg::LOW_PRE_SHIFT];

	logic [X1_W-1:0]       x1_s7;
	logic [X1_HI_W+27:0]   ph_s7;
	logic [43:0]           pl_s7;
	logic [PL_W-1:0]       prodl_s7;
	logic [MW-1:0]         mix_s7;
	alux_pkg::band_t       band_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			x1_s7    <= x1_d;
			ph_s7    <= (X1_HI_W + 28)'(x1_d[X1_W-1:16]) * (X1_HI_W + 28)'(alux_pkg::LOW_RECIP);
			pl_s7    <= 44'(x1_d[15:0]) * 44'(alux_pkg::LOW_RECIP);
			prodl_s7 <= prodl_s6;
			mix_s7   <= mix_s6;
			band_s7  <= band_s6;
		end
	end

	// ------------------------------------------------------------------
	// S8: sum partial products, take both approximate quotients.
	// ------------------------------------------------------------------
	logic [P1_W-1:0] prod1;

	assign prod1 = (P1_W'(ph_s7) << 16) + P1_W'(pl_s7);

	logic [X1_W-1:0] x1_s8;
	logic [27:0]     q1_s8, ql_s8;
	logic [MW-1:0]   mix_s8;
	alux_pkg::band_t band_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en_s8) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			x1_s8   <= x1_s7;
			q1_s8   <= prod1[P1_W-1:alux_pkg::LOW_RECIP_SHIFT];
			ql_s8   <= prodl_s7[PL_W-1:alux_pkg::MIX_RECIP_SHIFT];
			mix_s8  <= mix_s7;
			band_s8 <= band_s7;
		end
	end

	// ------------------------------------------------------------------
	// S9: one-step remainder correction, band select, output register.
	// ------------------------------------------------------------------
	logic [R1_W-1:0]  rem1;
	logic [RL_W-1:0]  reml;
	logic [27:0]      lux1, luxl;
	logic [alux_pkg::LUX_W-1:0] lux_in;

	assign rem1 = R1_W'(x1_s8) - R1_W'(q1_s8) * R1_W'(alux_pkg::LOW_DIV);
	assign reml = (RL_W'(mix_s8) << alux_pkg::MIX_UP_SHIFT)
	            - RL_W'(ql_s8) * RL_W'(alux_pkg::MIX_DIV);
	assign lux1 = q1_s8 + 28'(rem1 >= R1_W'(alux_pkg::LOW_DIV));
	assign luxl = ql_s8 + 28'(reml >= RL_W'(alux_pkg::MIX_DIV));

	always_comb begin
		case (band_s8)
			alux_pkg::BAND_LOW:   lux_in = alux_pkg::LUX_W'(lux1);
			alux_pkg::BAND_MID,
			alux_pkg::BAND_UPPER,
			alux_pkg::BAND_IR:    lux_in = alux_pkg::LUX_W'(luxl);
			default:              lux_in = '0;
		endcase
	end

	logic [alux_pkg::LUX_W-1:0] lux_s9;
	alux_pkg::band_t            band_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en_s9) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			lux_s9  <= lux_in;
			band_s9 <= band_s8;
		end
	end

	assign lux_valid = v_s9;
	assign lux_q16   = lux_s9;
	assign band      = band_s9;

endmodule

`default_nettype wire

// ===== hdl/alux_checker.sv =====
// Port-level checker for the lux block, bound to the top level.
`default_nettype none

module alux_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       pair_valid,
	input wire logic                       pair_stall,
	input wire logic [alux_pkg::CNT_W-1:0] broad_count,
	input wire logic [alux_pkg::CNT_W-1:0] ir_count,
	input wire logic                       lux_valid,
	input wire logic                       lux_stall,
	input wire logic [alux_pkg::LUX_W-1:0] lux_q16,
	input wire logic [2:0]                 band
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		lux_valid && lux_stall |=> lux_valid && $stable(lux_q16) && $stable(band))
		else $error("result beat changed while stalled");

	// zero broadband and out-of-range ratio give zero lux
	a_zero_band: assert property (@(posedge clk) disable iff (!arst_n)
		lux_valid && (band == alux_pkg::BAND_ZERO || band == alux_pkg::BAND_HIGH)
		|-> lux_q16 == '0)
		else $error("nonzero lux in a zero band");

	// input backpressure only when the result side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> lux_valid && lux_stall)
		else $error("input stalled without a stalled result");

endmodule

bind ambient_lux_from_two_channel_adc_top alux_checker u_alux_checker (.*);

`default_nettype wire
